[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(name, clk, rstn, prop) \
	name: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rstn, cond) \
	name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_PROP(name, clk, rstn, prop)
`define ASSERT_NEVER(name, clk, rstn, cond)
`endif
`endif

[rtl/pcrk_pkg.sv]
package pcrk_pkg;

	localparam int CAPTURE_BITS = 24;

	localparam logic [63:0] MEGA      = 64'd1000000;
	localparam logic [63:0] GIGA      = 64'd1000000000;
	localparam logic [63:0] TERA      = 64'd1000000000000;
	localparam logic [63:0] MEGA_SH8  = 64'd256000000;
	localparam logic [47:0] MASK48    = 48'hFFFF_FFFF_FFFF;

	localparam logic [25:0] CLOCK_HZ_RESET   = 26'd10000000;
	localparam logic [63:0] PROC_NOISE_RESET = 64'd15323000;
	localparam logic [63:0] MEAS_NOISE_RESET = 64'd768000000;
	localparam logic [47:0] TICK_RESET       = 48'd429496729600;

	typedef enum logic {
		OP_CAPTURE = 1'b0,
		OP_STAMP   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_CLOCK_HZ      = 2'd0,
		REG_PROCESS_NOISE = 2'd1,
		REG_MEAS_NOISE    = 2'd2,
		REG_TIME_OFFSET   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} arith_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_rsp_t;

endpackage

[rtl/pcrk_arith.sv]
`include "assert_macros.svh"

// Shared shift-add multiplier (64x64) and restoring divider (128/128),
// one bit per cycle through a single 129-bit adder.
module pcrk_arith import pcrk_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  arith_req_t   req,
	input  logic [127:0] a,
	input  logic [127:0] b,
	output arith_rsp_t   rsp,
	output logic [127:0] q,
	output logic [127:0] r
);

	localparam logic [6:0] MUL_LAST = 7'd63;
	localparam logic [6:0] DIV_LAST = 7'd127;

	logic         busy_q, div_q, done_q;
	logic [6:0]   cnt_q;
	logic [127:0] acc_q, num_q, b_q;
	logic [127:0] x, y;
	logic [128:0] sum;

	always_comb begin
		x   = div_q ? {acc_q[126:0], num_q[127]} : {acc_q[126:0], 1'b0};
		y   = div_q ? ~b_q : (num_q[127] ? b_q : '0);
		sum = {1'b0, x} + {1'b0, y} + {128'd0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				div_q  <= req.is_div;
				cnt_q  <= req.is_div ? DIV_LAST : MUL_LAST;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			num_q <= req.is_div ? a : {a[63:0], 64'd0};
			b_q   <= b;
		end else if (busy_q) begin
			if (div_q) begin
				acc_q <= sum[128] ? sum[127:0] : x;
				num_q <= {num_q[126:0], sum[128]};
			end else begin
				acc_q <= sum[127:0];
				num_q <= {num_q[126:0], 1'b0};
			end
		end
	end

	assign q        = div_q ? num_q : acc_q;
	assign r        = acc_q;
	assign rsp.busy = busy_q;
	assign rsp.done = done_q;

	`ASSERT_PROP(a_start_when_idle, clk, arst_n, req.start |-> !busy_q)
	`ASSERT_PROP(a_done_ends_run, clk, arst_n, done_q |-> $past(busy_q))
	`ASSERT_PROP(a_run_from_start, clk, arst_n, $rose(busy_q) |-> $past(req.start))

endmodule

[rtl/pps_clock_rate_kalman.sv]
// Clock rate Kalman filter and timestamp unit for PPS-disciplined counters.
// Input beats (s_*): tuser selects a PPS period capture or a stamp request;
// tdata carries pps_index, period_ticks and count_ticks. Output beats (m_*)
// carry a filter result (kind 0) for captures that update the filter, and
// a stamp (kind 1) for every request. Captures with index below two, or not
// newer than the last used index, give no output beat.
// The block handles one beat at a time; s_tready is low while it works.
// All multiplies and divides run through one shared bit-serial unit. A stamp
// request that comes before the filter is seeded goes to the output without
// arithmetic. The output register holds a result until m_tready; a stalled
// receiver holds the block in its final state, no beat is lost.
// Reset clears the filter, loads the register defaults and gives a tick
// period of 100 ns. Register writes (cfg_*) take effect at once and are
// meant for idle periods only.
`include "assert_macros.svh"

module pps_clock_rate_kalman import pcrk_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_addr,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pps_index[31:0], period_ticks[55:32], count_ticks[80:56], zero pad
	input  logic [87:0]  s_tdata,
	// op[0]
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// stamp_valid[0], seconds[32:1], nanoseconds[62:33], rate_ppm[110:63],
	// saturated[111]
	output logic [111:0] m_tdata,
	// kind[0]
	output logic [0:0]   m_tuser
);

	localparam logic [23:0] PERIOD_MASK =
		(CAPTURE_BITS >= 24) ? 24'hFF_FFFF : 24'((64'd1 << CAPTURE_BITS) - 64'd1);
	localparam logic [47:0] X_MAX  = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] X_MIN  = 48'h8000_0000_0000;
	localparam logic [50:0] DM_MAX = 51'h4_0000_0000_0000;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SD_M1, ST_SD_D1, ST_SD_M2, ST_SD_M3, ST_SD_D2, ST_SD_D3,
		ST_C_M0, ST_C_M1, ST_C_M2, ST_C_M3, ST_C_G, ST_C_M4, ST_C_D1,
		ST_C_M5, ST_C_M6, ST_C_D2, ST_C_M7, ST_C_M8, ST_C_D3, ST_C_D4,
		ST_T_M, ST_T_D,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [25:0]  clock_hz_q;
	logic [63:0]  proc_noise_q, meas_noise_q;
	logic [31:0]  time_offset_q;

	logic signed [47:0] x_q;
	logic [63:0]  p_q;
	logic [47:0]  tick_q;
	logic [31:0]  last_q, latest_q;
	logic         seeded_q;

	logic         wait_q, op_q, sat_q;
	logic [31:0]  idx_q, sec_q;
	logic signed [26:0] z_q;
	logic [63:0]  p1_q;
	logic [51:0]  cc_q;
	logic [91:0]  a_q;
	logic [104:0] d_q;
	logic [32:0]  g_q;
	logic signed [52:0] y_q;
	logic [58:0]  den_q;
	logic [25:0]  t_q;
	logic [29:0]  ns_q;

	logic         m_tvalid_q;
	logic [111:0] m_tdata_q;
	logic         m_tuser_q;

	arith_req_t   ar_req;
	arith_rsp_t   ar_rsp;
	logic [127:0] ar_a, ar_b, ar_q, ar_r;
	logic         ar_div;

	logic         s_acc;
	logic [31:0]  in_idx;
	logic [23:0]  in_period;
	logic signed [24:0] in_count;

	logic [25:0]  c_eff;
	logic [25:0]  zmag;
	logic [47:0]  xmag;
	logic [52:0]  ymag;
	logic [96:0]  p1_sum;
	logic [63:0]  p1_next;
	logic [104:0] d_next;
	logic signed [52:0] zs, kxs, y_next;
	logic [63:0]  dm_sat;
	logic [50:0]  dmag;
	logic signed [52:0] xsum;
	logic [63:0]  xsum_mag;
	logic signed [59:0] den_next;
	logic signed [26:0] t_wrap;
	logic [25:0]  t_next;
	logic [31:0]  sec_next;
	logic [48:0]  seed_clip, corr_clip;

	function automatic logic [63:0] sat64(input logic [127:0] v);
		sat64 = (v[127:64] != '0) ? '1 : v[63:0];
	endfunction

	// {saturated, value}
	function automatic logic [48:0] clip48(input logic neg, input logic [63:0] mag);
		logic [63:0] neg_mag;
		neg_mag = -mag;
		if (neg) begin
			if (mag > 64'h8000_0000_0000) clip48 = {1'b1, X_MIN};
			else clip48 = {1'b0, neg_mag[47:0]};
		end else begin
			if (mag > {16'd0, X_MAX}) clip48 = {1'b1, X_MAX};
			else clip48 = {1'b0, mag[47:0]};
		end
	endfunction

	assign s_acc     = s_tvalid && s_tready;
	assign in_idx    = s_tdata[31:0];
	assign in_period = s_tdata[55:32] & PERIOD_MASK;
	assign in_count  = s_tdata[80:56];

	always_comb begin
		c_eff    = (clock_hz_q == '0) ? 26'd1 : clock_hz_q;
		zmag     = z_q[26] ? 26'(-z_q) : 26'(z_q);
		xmag     = x_q[47] ? 48'(-x_q) : 48'(x_q);
		ymag     = y_q[52] ? 53'(-y_q) : 53'(y_q);
		p1_sum   = {1'b0, ar_q[95:0]} + {33'd0, p_q};
		p1_next  = (p1_sum[96:64] != '0) ? '1 : p1_sum[63:0];
		d_next   = {13'd0, a_q} + {1'b0, ar_q[103:0]};
		zs       = {{2{z_q[26]}}, z_q, 24'd0};
		kxs      = {7'd0, ar_q[45:0]};
		y_next   = x_q[47] ? (zs + kxs) : (zs - kxs);
		dm_sat   = sat64(ar_q);
		dmag     = (dm_sat > {13'd0, DM_MAX}) ? DM_MAX : dm_sat[50:0];
		xsum     = y_q[52] ? ({{5{x_q[47]}}, x_q} - {2'b0, dmag})
		                   : ({{5{x_q[47]}}, x_q} + {2'b0, dmag});
		xsum_mag = xsum[52] ? 64'(-xsum) : 64'(xsum);
		den_next = x_q[47] ? ({2'b0, c_eff, 32'd0} - {6'd0, ar_q[53:0]})
		                   : ({2'b0, c_eff, 32'd0} + {6'd0, ar_q[53:0]});
		t_wrap   = 27'(in_count) + {1'b0, c_eff};
		if (!in_count[24]) begin
			t_next   = {2'd0, in_count[23:0]};
			sec_next = time_offset_q + latest_q;
		end else begin
			t_next   = t_wrap[26] ? '0 : t_wrap[25:0];
			sec_next = time_offset_q + latest_q - 32'd1;
		end
		seed_clip = clip48(z_q[26], sat64(ar_q));
		corr_clip = clip48(xsum[52], xsum_mag);
	end

	always_comb begin
		ar_a   = '0;
		ar_b   = '0;
		ar_div = 1'b0;
		unique case (state_q)
			ST_SD_M1: begin
				ar_a = {70'd0, zmag, 32'd0};
				ar_b = {64'd0, MEGA};
			end
			ST_SD_D1: begin
				ar_div = 1'b1;
				ar_a   = ar_q;
				ar_b   = {102'd0, c_eff};
			end
			ST_SD_M2, ST_C_M0: begin
				ar_a = {102'd0, c_eff};
				ar_b = {102'd0, c_eff};
			end
			ST_SD_M3, ST_C_M3: begin
				ar_a = {64'd0, meas_noise_q};
				ar_b = {64'd0, TERA};
			end
			ST_SD_D2: begin
				ar_div = 1'b1;
				ar_a   = {ar_q[103:0], 24'd0};
				ar_b   = {76'd0, cc_q};
			end
			ST_SD_D3: begin
				ar_div = 1'b1;
				ar_a   = {32'd0, GIGA, 32'd0};
				ar_b   = {102'd0, c_eff};
			end
			ST_C_M1: begin
				ar_a = {96'd0, idx_q - last_q};
				ar_b = {64'd0, proc_noise_q};
			end
			ST_C_M2: begin
				ar_a = {76'd0, cc_q};
				ar_b = {64'd0, p1_q};
			end
			ST_C_G: begin
				ar_div = 1'b1;
				ar_a   = {4'd0, a_q, 32'd0};
				ar_b   = {23'd0, d_q};
			end
			ST_C_M4, ST_C_M8: begin
				ar_a = {102'd0, c_eff};
				ar_b = {80'd0, xmag};
			end
			ST_C_D1: begin
				ar_div = 1'b1;
				ar_a   = ar_q;
				ar_b   = {64'd0, MEGA_SH8};
			end
			ST_C_M5: begin
				ar_a = {95'd0, g_q};
				ar_b = {64'd0, MEGA};
			end
			ST_C_M6: begin
				ar_a = {64'd0, ar_q[63:0]};
				ar_b = {75'd0, ymag};
			end
			ST_C_D2: begin
				ar_div = 1'b1;
				ar_a   = ar_q;
				ar_b   = {78'd0, c_eff, 24'd0};
			end
			ST_C_M7: begin
				ar_a = {64'd0, p1_q};
				ar_b = {95'd0, 33'h1_0000_0000 - g_q};
			end
			ST_C_D3: begin
				ar_div = 1'b1;
				ar_a   = ar_q;
				ar_b   = {64'd0, MEGA};
			end
			ST_C_D4: begin
				ar_div = 1'b1;
				ar_a   = {GIGA, 64'd0};
				ar_b   = {69'd0, den_q};
			end
			ST_T_M: begin
				ar_a = {80'd0, tick_q};
				ar_b = {102'd0, t_q};
			end
			ST_T_D: begin
				ar_div = 1'b1;
				ar_a   = {64'd0, ar_q[95:32]};
				ar_b   = {64'd0, GIGA};
			end
			ST_IDLE, ST_DONE: begin
				ar_div = 1'b0;
			end
			default: begin
				ar_div = 1'b0;
			end
		endcase
		ar_req.start  = (state_q != ST_IDLE) && (state_q != ST_DONE) && !wait_q;
		ar_req.is_div = ar_div;
	end

	pcrk_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ar_req),
		.a      (ar_a),
		.b      (ar_b),
		.rsp    (ar_rsp),
		.q      (ar_q),
		.r      (ar_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			clock_hz_q    <= CLOCK_HZ_RESET;
			proc_noise_q  <= PROC_NOISE_RESET;
			meas_noise_q  <= MEAS_NOISE_RESET;
			time_offset_q <= '0;
			x_q           <= '0;
			p_q           <= '0;
			tick_q        <= TICK_RESET;
			last_q        <= '0;
			latest_q      <= '0;
			seeded_q      <= 1'b0;
			wait_q        <= 1'b0;
			op_q          <= 1'b0;
			sat_q         <= 1'b0;
			idx_q         <= '0;
			sec_q         <= '0;
			z_q           <= '0;
			p1_q          <= '0;
			cc_q          <= '0;
			a_q           <= '0;
			d_q           <= '0;
			g_q           <= '0;
			y_q           <= '0;
			den_q         <= '0;
			t_q           <= '0;
			ns_q          <= '0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
			m_tuser_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_addr)
					REG_CLOCK_HZ:      clock_hz_q    <= cfg_data[25:0];
					REG_PROCESS_NOISE: proc_noise_q  <= cfg_data;
					REG_MEAS_NOISE:    meas_noise_q  <= cfg_data;
					REG_TIME_OFFSET:   time_offset_q <= cfg_data[31:0];
					default:           time_offset_q <= time_offset_q;
				endcase
			end

			if (m_tvalid_q && m_tready && state_q != ST_DONE) m_tvalid_q <= 1'b0;

			if (ar_req.start) wait_q <= 1'b1;
			else if (ar_rsp.done) wait_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						op_q  <= s_tuser[0];
						sat_q <= 1'b0;
						if (s_tuser[0] == OP_CAPTURE) begin
							latest_q <= in_idx;
							idx_q    <= in_idx;
							z_q      <= $signed({3'd0, in_period}) - $signed({1'b0, c_eff});
							if (in_idx < 32'd2) state_q <= ST_IDLE;
							else if (!seeded_q) state_q <= ST_SD_M1;
							else if (in_idx <= last_q) state_q <= ST_IDLE;
							else state_q <= ST_C_M0;
						end else begin
							t_q   <= t_next;
							sec_q <= sec_next;
							state_q <= seeded_q ? ST_T_M : ST_DONE;
						end
					end
				end
				ST_SD_M1: if (ar_rsp.done) state_q <= ST_SD_D1;
				ST_SD_D1: begin
					if (ar_rsp.done) begin
						sat_q   <= seed_clip[48];
						x_q     <= seed_clip[47:0];
						state_q <= ST_SD_M2;
					end
				end
				ST_SD_M2: begin
					if (ar_rsp.done) begin
						cc_q    <= ar_q[51:0];
						state_q <= ST_SD_M3;
					end
				end
				ST_SD_M3: if (ar_rsp.done) state_q <= ST_SD_D2;
				ST_SD_D2: begin
					if (ar_rsp.done) begin
						p_q     <= sat64(ar_q);
						state_q <= ST_SD_D3;
					end
				end
				ST_SD_D3: begin
					if (ar_rsp.done) begin
						tick_q   <= (ar_q > {80'd0, MASK48}) ? MASK48 : ar_q[47:0];
						seeded_q <= 1'b1;
						state_q  <= ST_DONE;
					end
				end
				ST_C_M0: begin
					if (ar_rsp.done) begin
						cc_q    <= ar_q[51:0];
						state_q <= ST_C_M1;
					end
				end
				ST_C_M1: begin
					if (ar_rsp.done) begin
						p1_q    <= p1_next;
						state_q <= ST_C_M2;
					end
				end
				ST_C_M2: begin
					if (ar_rsp.done) begin
						a_q     <= ar_q[115:24];
						state_q <= ST_C_M3;
					end
				end
				ST_C_M3: begin
					if (ar_rsp.done) begin
						d_q <= d_next;
						if (d_next == '0) begin
							g_q     <= '0;
							state_q <= ST_C_M4;
						end else begin
							state_q <= ST_C_G;
						end
					end
				end
				ST_C_G: begin
					if (ar_rsp.done) begin
						g_q     <= ar_q[32:0];
						state_q <= ST_C_M4;
					end
				end
				ST_C_M4: if (ar_rsp.done) state_q <= ST_C_D1;
				ST_C_D1: begin
					if (ar_rsp.done) begin
						y_q     <= y_next;
						state_q <= ST_C_M5;
					end
				end
				ST_C_M5: if (ar_rsp.done) state_q <= ST_C_M6;
				ST_C_M6: if (ar_rsp.done) state_q <= ST_C_D2;
				ST_C_D2: begin
					if (ar_rsp.done) begin
						sat_q   <= corr_clip[48];
						x_q     <= corr_clip[47:0];
						state_q <= ST_C_M7;
					end
				end
				ST_C_M7: begin
					if (ar_rsp.done) begin
						p_q     <= ar_q[95:32];
						state_q <= ST_C_M8;
					end
				end
				ST_C_M8: if (ar_rsp.done) state_q <= ST_C_D3;
				ST_C_D3: begin
					if (ar_rsp.done) begin
						if (den_next[59] || den_next == '0) begin
							tick_q  <= MASK48;
							state_q <= ST_DONE;
						end else begin
							den_q   <= den_next[58:0];
							state_q <= ST_C_D4;
						end
					end
				end
				ST_C_D4: begin
					if (ar_rsp.done) begin
						tick_q  <= (ar_q > {80'd0, MASK48}) ? MASK48 : ar_q[47:0];
						state_q <= ST_DONE;
					end
				end
				ST_T_M: if (ar_rsp.done) state_q <= ST_T_D;
				ST_T_D: begin
					if (ar_rsp.done) begin
						sec_q   <= sec_q + ar_q[31:0];
						ns_q    <= ar_r[29:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= op_q;
						if (op_q == OP_CAPTURE) begin
							last_q    <= idx_q;
							m_tdata_q <= {sat_q, x_q, 30'd0, time_offset_q + idx_q, 1'b1};
						end else if (seeded_q) begin
							m_tdata_q <= {1'b0, x_q, ns_q, sec_q, 1'b1};
						end else begin
							m_tdata_q <= {1'b0, x_q, 30'd0, 32'd0, 1'b0};
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`ASSERT_PROP(a_unit_free_on_start, clk, arst_n, ar_req.start |-> !ar_rsp.busy)
	`ASSERT_PROP(a_seed_sticks, clk, arst_n, seeded_q |=> seeded_q)
	`ASSERT_PROP(a_beat_from_done, clk, arst_n, $rose(m_tvalid) |-> $past(state_q == ST_DONE))
	`ASSERT_NEVER(a_no_accept_in_flight, clk, arst_n, s_tready && wait_q)

endmodule

[sim/tb.sv]
`default_nettype none

class drift_scoreboard;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] TWO_POW_47 = 64'h0000_8000_0000_0000;

	logic [63:0] clock_hz, proc_noise, meas_noise, offset_sec;
	longint      rate_est;
	logic [63:0] err_var, tick_ns;
	logic [31:0] last_idx, latest_idx;
	bit          seeded;

	logic [112:0] pending[$];
	int           n_err, n_checked, n_stamps, n_updates, n_sat;

	function new();
		clock_hz   = 64'(pcrk_pkg::CLOCK_HZ_RESET);
		proc_noise = pcrk_pkg::PROC_NOISE_RESET;
		meas_noise = pcrk_pkg::MEAS_NOISE_RESET;
		offset_sec = 0;
		rate_est   = 0;
		err_var    = 0;
		last_idx   = 0;
		latest_idx = 0;
		seeded     = 0;
		tick_ns    = (pcrk_pkg::GIGA << 32) / clock_hz;
	endfunction

	function void write_reg(pcrk_pkg::reg_idx_t idx, logic [63:0] val);
		case (idx)
			pcrk_pkg::REG_CLOCK_HZ:      clock_hz = {38'd0, val[25:0]};
			pcrk_pkg::REG_PROCESS_NOISE: proc_noise = val;
			pcrk_pkg::REG_MEAS_NOISE:    meas_noise = val;
			pcrk_pkg::REG_TIME_OFFSET:   offset_sec = {32'd0, val[31:0]};
		endcase
	endfunction

	function logic [63:0] clk_eff();
		return clock_hz == 0 ? 64'd1 : clock_hz;
	endfunction

	function logic [63:0] sat64(logic [127:0] a);
		return a[127:64] != 0 ? ALL_ONES : a[63:0];
	endfunction

	function logic [63:0] mag(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function longint clip_q16_32(bit neg, logic [63:0] m, inout bit sat);
		if (neg) begin
			if (m > TWO_POW_47) begin
				sat = 1;
				return -longint'(TWO_POW_47);
			end
			return -longint'(m);
		end
		if (m > TWO_POW_47 - 1) begin
			sat = 1;
			return longint'(TWO_POW_47 - 1);
		end
		return longint'(m);
	endfunction

	function void update_tick_period();
		logic [63:0]  c, kx;
		logic [127:0] q;
		longint       den;
		c = clk_eff();
		kx = 64'((128'(c) * 128'(mag(rate_est))) / 128'(pcrk_pkg::MEGA));
		den = longint'(c << 32) + (rate_est < 0 ? -longint'(kx) : longint'(kx));
		if (den <= 0) begin
			tick_ns = 64'(pcrk_pkg::MASK48);
			return;
		end
		q = {pcrk_pkg::GIGA, 64'd0} / {64'd0, 64'(den)};
		tick_ns = sat64(q);
		if (tick_ns > 64'(pcrk_pkg::MASK48))
			tick_ns = 64'(pcrk_pkg::MASK48);
	endfunction

	function void seed_filter(longint z, inout bit sat);
		logic [63:0]  c;
		logic [127:0] num, pv;
		c = clk_eff();
		num = 128'(mag(z) << 32) * 128'(pcrk_pkg::MEGA);
		rate_est = clip_q16_32(z < 0, sat64(num / 128'(c)), sat);
		pv = (128'(meas_noise) * 128'(pcrk_pkg::TERA)) << 24;
		err_var = sat64(pv / 128'(c * c));
		tick_ns = (pcrk_pkg::GIGA << 32) / c;
		if (tick_ns > 64'(pcrk_pkg::MASK48))
			tick_ns = 64'(pcrk_pkg::MASK48);
	endfunction

	function void correct_filter(longint z, logic [31:0] dt, inout bit sat);
		logic [63:0]  c, p1, gain, kx, dmag;
		logic [127:0] a, d, prod;
		longint       innov, sum;
		c = clk_eff();
		p1 = sat64(128'(dt) * 128'(proc_noise) + 128'(err_var));
		a = (128'(c * c) * 128'(p1)) >> 24;
		d = a + 128'(meas_noise) * 128'(pcrk_pkg::TERA);
		gain = d == 0 ? 64'd0 : 64'((a << 32) / d);
		kx = 64'((128'(c) * 128'(mag(rate_est))) / 128'(pcrk_pkg::MEGA_SH8));
		innov = z * 64'sd16777216 - (rate_est < 0 ? -longint'(kx) : longint'(kx));
		prod = 128'(gain * pcrk_pkg::MEGA) * 128'(mag(innov));
		dmag = sat64(prod / 128'(c << 24));
		if (dmag > (64'd1 << 50))
			dmag = 64'd1 << 50;
		sum = rate_est + (innov < 0 ? -longint'(dmag) : longint'(dmag));
		rate_est = clip_q16_32(sum < 0, mag(sum), sat);
		err_var = 64'((128'(p1) * 128'((64'd1 << 32) - gain)) >> 32);
		update_tick_period();
	endfunction

	// expected beat: {kind, saturated, rate, ns, sec, stamp_valid}
	function void note_input(pcrk_pkg::op_t op, logic [31:0] idx, logic [23:0] period,
			logic [24:0] count);
		logic [63:0] c, sec, ns;
		longint      z, t;
		bit          sat;
		bit          valid;
		c = clk_eff();
		sat = 0;
		valid = 0;
		sec = 0;
		ns = 0;
		if (op == pcrk_pkg::OP_CAPTURE) begin
			z = longint'({40'd0, period}) - longint'(c);
			latest_idx = idx;
			if (idx < 2)
				return;
			if (!seeded) begin
				seed_filter(z, sat);
				seeded = 1;
			end else begin
				if (idx <= last_idx)
					return;
				correct_filter(z, idx - last_idx, sat);
			end
			last_idx = idx;
			valid = 1;
			sec = offset_sec + 64'(idx);
			n_updates++;
			if (sat)
				n_sat++;
		end else begin
			n_stamps++;
			if (seeded) begin
				t = longint'($signed(count));
				sec = offset_sec + 64'(latest_idx);
				if (t < 0) begin
					sec = sec - 1;
					t = t + longint'(c);
					if (t < 0)
						t = 0;
				end
				ns = 64'((128'(tick_ns) * 128'(t)) >> 32);
				sec = sec + ns / pcrk_pkg::GIGA;
				ns = ns % pcrk_pkg::GIGA;
				valid = 1;
			end
		end
		pending.push_back({op == pcrk_pkg::OP_STAMP, sat, 48'(rate_est), ns[29:0], sec[31:0],
			valid});
	endfunction

	function void check_beat(logic [111:0] data, logic [0:0] kind);
		logic [112:0] exp_beat;
		if (pending.size() == 0) begin
			n_err++;
			if (n_err <= 10)
				$display("unexpected output beat: kind %0d data %h", kind, data);
			return;
		end
		exp_beat = pending.pop_front();
		n_checked++;
		if ({kind, data} !== exp_beat) begin
			n_err++;
			if (n_err <= 10) begin
				$display("mismatch on beat %0d:", n_checked);
				$display("  kind  exp %0d got %0d", exp_beat[112], kind);
				$display("  valid exp %0d got %0d", exp_beat[0], data[0]);
				$display("  sec   exp %0d got %0d", exp_beat[32:1], data[32:1]);
				$display("  ns    exp %0d got %0d", exp_beat[62:33], data[62:33]);
				$display("  rate  exp %h got %h", exp_beat[110:63], data[110:63]);
				$display("  sat   exp %0d got %0d", exp_beat[111], data[111]);
			end
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pcrk_pkg::*;

	localparam longint CYCLE_LIMIT = 40000000;
	localparam int     SETTLE = 3000;

	logic         clk;
	logic         arst_n;
	logic         cfg_wr_en;
	logic [1:0]   cfg_addr;
	logic [63:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [87:0]  s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;
	logic [0:0]   m_tuser;

	drift_scoreboard sb;
	longint cycles;
	bit     quiet;
	int     n_sent;
	logic [31:0] cur_idx;

	pps_clock_rate_kalman dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tdata, m_tuser);

	// receiver stalls
	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) < 2) begin
				n = $urandom_range(1, 19);
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	task automatic write_regs(logic [63:0] hz, logic [63:0] q, logic [63:0] r,
			logic [63:0] off);
		logic [63:0] vals[4];
		vals = '{hz, q, r, off};
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en <= 1;
			cfg_addr <= 2'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(reg_idx_t'(i), vals[i]);
		end
		cfg_wr_en <= 0;
	endtask

	task automatic send(op_t op, logic [31:0] idx, logic [23:0] period, logic [24:0] count);
		if (!quiet && $urandom_range(0, 9) < 2) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {7'd0, count, period, idx};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(op, idx, period, count);
		n_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_items(int n);
		logic [63:0] c;
		logic [23:0] p;
		int r;
		c = sb.clk_eff();
		for (int i = 0; i < n; i++) begin
			quiet = n_sent > 800;
			r = $urandom_range(0, 99);
			if (r < 55) begin
				if ($urandom_range(0, 9) != 0)
					cur_idx = cur_idx + 1;
				else
					cur_idx = cur_idx + $urandom_range(2, 60);
				p = 24'(c) + 24'($urandom_range(0, 4000)) - 24'd2000;
				send(OP_CAPTURE, cur_idx, p, 25'($urandom));
			end else if (r < 62) begin
				cur_idx = cur_idx + $urandom_range(1, 3);
				send(OP_CAPTURE, cur_idx, 24'($urandom), 25'($urandom));
			end else if (r < 68) begin
				send(OP_CAPTURE, $urandom_range(0, cur_idx), 24'($urandom), 25'($urandom));
				send(OP_CAPTURE, cur_idx, 24'(c), 25'($urandom));
			end else begin
				send(OP_STAMP, $urandom, 24'($urandom),
					25'($signed(25'($urandom)) >>> $urandom_range(0, 24)));
			end
		end
	endtask

	initial begin
		sb = new();
		cycles = 0;
		quiet = 0;
		n_sent = 0;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_addr = 0;
		cfg_data = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: requests before seeding, low indices, seed, count extremes
		send(OP_STAMP, 0, 0, 25'd0);
		send(OP_STAMP, 0, 0, 25'h1FF_FFFF);
		send(OP_CAPTURE, 0, 24'd10000000, 0);
		send(OP_CAPTURE, 1, 24'd10000000, 0);
		send(OP_CAPTURE, 2, 24'd10000000, 0);
		send(OP_STAMP, 0, 0, 25'h0FF_FFFF);
		send(OP_STAMP, 0, 0, 25'h100_0000);
		send(OP_STAMP, 0, 0, 25'd0);
		send(OP_STAMP, 0, 0, 25'h1FF_FFFF);
		send(OP_CAPTURE, 2, 24'd10000500, 0);
		send(OP_CAPTURE, 1, 24'd10000500, 0);
		send(OP_CAPTURE, 3, 24'd0, 0);
		send(OP_CAPTURE, 4, 24'hFF_FFFF, 0);
		send(OP_CAPTURE, 5, 24'd10000000, 0);
		send(OP_STAMP, 0, 0, 25'd9999999);
		cur_idx = 5;
		random_items(150);
		drain();

		write_regs(64'd32768, 64'd0, 64'd0, 64'hFFFF_FFFF);
		cur_idx = cur_idx + $urandom_range(1, 1 << 20);
		random_items(150);
		drain();

		write_regs(64'd50000000, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'(32'($urandom)));
		cur_idx = cur_idx + $urandom_range(1, 1 << 28);
		random_items(150);
		drain();

		write_regs(64'(26'($urandom_range(32768, 16000000))), {$urandom, $urandom} >> 20,
			{$urandom, $urandom} >> 24, 64'(32'($urandom)));
		cur_idx = 32'hF000_0000 | 32'($urandom_range(0, 1 << 20));
		random_items(150);
		drain();

		write_regs(64'd10000000, 64'd15323000, 64'd768000000, 64'hFFFF_FF00);
		random_items(180);
		send(OP_CAPTURE, 32'hFFFF_FFFF, 24'd10000000, 0);
		send(OP_STAMP, 0, 0, 25'h0FF_FFFF);
		drain();

		$display("%0d input beats, %0d results checked:", n_sent, sb.n_checked);
		$display("%0d filter updates (%0d clipped), %0d stamps",
			sb.n_updates, sb.n_sat, sb.n_stamps);
		$display("register settings covered clock extremes and zero and full-scale noise");
		if (sb.n_err == 0 && sb.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.n_err, sb.pending.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
